// File: hw/rtl/lfu_pkg.sv
// lfu_pkg: shared constants, state and command codes, control structs
// used by the scan unit and the cache table core
`timescale 1ns / 1ps

package lfu_pkg;

    localparam int ENTRIES_DEFAULT    = 16;
    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int CAP_W              = 5;
    localparam int KEY_W              = 32;
    localparam int DATA_W             = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    typedef struct packed {
        logic clr;
        logic scan;
        logic upd;
    } unit_ctl_t;

    typedef struct packed {
        logic found;
        logic victim;
        logic free;
    } scan_flags_t;

endpackage

// File: hw/rtl/lfu_entry_ram.sv
// lfu_entry_ram: one-write one-read entry memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module lfu_entry_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 84,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/lfu_scan_unit.sv
// lfu_scan_unit: shared per-entry compare and update unit
// key match, victim choice, free slot search and rank/count rewrite; uses lfu_pkg
`timescale 1ns / 1ps

module lfu_scan_unit #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEFAULT,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEFAULT,
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lfu_pkg::unit_ctl_t          ctl,
    input  logic [IDX_W-1:0]            idx,
    input  logic                        ent_valid,
    input  logic [lfu_pkg::KEY_W-1:0]   ent_key,
    input  logic [lfu_pkg::DATA_W-1:0]  ent_data,
    input  logic [COUNT_BITS-1:0]       ent_count,
    input  logic [IDX_W-1:0]            ent_rank,
    input  logic [lfu_pkg::KEY_W-1:0]   key,
    input  logic [IDX_W-1:0]            tgt_idx,
    input  logic                        tgt_all,
    input  logic [IDX_W-1:0]            tgt_rank,
    input  logic [lfu_pkg::DATA_W-1:0]  tgt_data,
    input  logic [COUNT_BITS-1:0]       tgt_count,
    output lfu_pkg::scan_flags_t        flags,
    output logic [IDX_W-1:0]            found_idx,
    output logic [lfu_pkg::DATA_W-1:0]  found_data,
    output logic [COUNT_BITS-1:0]       found_count,
    output logic [IDX_W-1:0]            found_rank,
    output logic [IDX_W-1:0]            victim_idx,
    output logic [IDX_W-1:0]            victim_rank,
    output logic [IDX_W-1:0]            free_idx,
    output logic                        wr_en,
    output logic [lfu_pkg::KEY_W-1:0]   wr_key,
    output logic [lfu_pkg::DATA_W-1:0]  wr_data,
    output logic [COUNT_BITS-1:0]       wr_count,
    output logic [IDX_W-1:0]            wr_rank
);

    lfu_pkg::scan_flags_t flags_reg, flags_next;

    logic [IDX_W-1:0]           found_idx_reg;
    logic [lfu_pkg::DATA_W-1:0] found_data_reg;
    logic [COUNT_BITS-1:0]      found_count_reg;
    logic [IDX_W-1:0]           found_rank_reg;
    logic [IDX_W-1:0]           victim_idx_reg;
    logic [COUNT_BITS-1:0]      victim_count_reg;
    logic [IDX_W-1:0]           victim_rank_reg;
    logic [IDX_W-1:0]           free_idx_reg;

    logic take_match;
    logic take_victim;
    logic take_free;
    logic is_tgt;
    logic ages;

    assign take_match = ctl.scan && ent_valid && (ent_key == key) && !flags_reg.found;
    assign take_victim = ctl.scan && ent_valid &&
                         (!flags_reg.victim || (ent_count < victim_count_reg) ||
                          ((ent_count == victim_count_reg) && (ent_rank > victim_rank_reg)));
    assign take_free = ctl.scan && !ent_valid && !flags_reg.free;

    always_comb
    begin
        flags_next = flags_reg;
        if (ctl.clr)
        begin
            flags_next = '0;
        end
        else
        begin
            if (take_match)
            begin
                flags_next.found = 1'b1;
            end
            if (take_victim)
            begin
                flags_next.victim = 1'b1;
            end
            if (take_free)
            begin
                flags_next.free = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_match)
        begin
            found_idx_reg   <= idx;
            found_data_reg  <= ent_data;
            found_count_reg <= ent_count;
            found_rank_reg  <= ent_rank;
        end
        if (take_victim)
        begin
            victim_idx_reg   <= idx;
            victim_count_reg <= ent_count;
            victim_rank_reg  <= ent_rank;
        end
        if (take_free)
        begin
            free_idx_reg <= idx;
        end
    end

    assign flags       = flags_reg;
    assign found_idx   = found_idx_reg;
    assign found_data  = found_data_reg;
    assign found_count = found_count_reg;
    assign found_rank  = found_rank_reg;
    assign victim_idx  = victim_idx_reg;
    assign victim_rank = victim_rank_reg;
    assign free_idx    = free_idx_reg;

    // update: target rewritten, newer valid entries (all on insert) age by one
    assign is_tgt = (idx == tgt_idx);
    assign ages   = ent_valid && (tgt_all || (ent_rank < tgt_rank));
    assign wr_en  = ctl.upd && (is_tgt || ages);

    always_comb
    begin
        if (is_tgt)
        begin
            wr_key   = key;
            wr_data  = tgt_data;
            wr_count = tgt_count;
            wr_rank  = '0;
        end
        else
        begin
            wr_key   = ent_key;
            wr_data  = ent_data;
            wr_count = ent_count;
            wr_rank  = ent_rank + 1'b1;
        end
    end

endmodule

// File: hw/rtl/lfu_cache_table_core.sv
// lfu_cache_table_core: top level of the lfu cache with lru tie break
// sequencer, valid bits and occupancy; uses lfu_pkg, lfu_entry_ram, lfu_scan_unit
`timescale 1ns / 1ps

// channel   | handshake                    | payload
// ----------+------------------------------+--------------------------------
// command   | start, busy (start & !busy)  | command, key, data_value
// result    | result_valid (one cycle)     | hit, read_value
// config    | cfg_valid, cfg_ready         | cfg_data (capacity_in_use)
//
// a transaction runs a scan pass and, when something is written back, an update
// pass, each stepping one entry per cycle through the single read port of the
// entry ram. busy rises after acceptance and stays high through the strobe cycle;
// a new start is taken the cycle after. reset clears valid bits and occupancy and
// sets capacity to 16 at once.
// the result is strobed for one cycle and cannot be stalled.

module lfu_cache_table_core #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEFAULT,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              command,
    input  logic signed [lfu_pkg::KEY_W-1:0]  key,
    input  logic signed [lfu_pkg::DATA_W-1:0] data_value,
    output logic                              result_valid,
    output logic                              hit,
    output logic signed [lfu_pkg::DATA_W-1:0] read_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]         cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = ((OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W) + 1;
    localparam int ENT_W = lfu_pkg::KEY_W + lfu_pkg::DATA_W + COUNT_BITS + IDX_W;

    lfu_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         pv_reg, pv_next;
    logic [IDX_W-1:0]             pidx_reg, pidx_next;
    logic [lfu_pkg::CAP_W-1:0]    cap_reg, cap_next;
    logic [OCC_W-1:0]             occ_reg, occ_next;
    logic [ENTRIES-1:0]           valid_reg, valid_next;
    lfu_pkg::cmd_t                cmd_reg, cmd_next;
    logic [lfu_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [lfu_pkg::DATA_W-1:0]   val_reg, val_next;
    logic [IDX_W-1:0]             tgt_idx_reg, tgt_idx_next;
    logic                         tgt_all_reg, tgt_all_next;
    logic [IDX_W-1:0]             tgt_rank_reg, tgt_rank_next;
    logic [lfu_pkg::DATA_W-1:0]   tgt_data_reg, tgt_data_next;
    logic [COUNT_BITS-1:0]        tgt_count_reg, tgt_count_next;
    logic                         res_hit_reg, res_hit_next;
    logic [lfu_pkg::DATA_W-1:0]   res_val_reg, res_val_next;

    logic                         accept;
    logic                         issue;
    logic                         last;
    logic [IDX_W-1:0]             raddr;
    logic [CMP_W-1:0]             cap_wide;
    logic [CMP_W-1:0]             cap_eff;
    logic                         full;
    logic [COUNT_BITS-1:0]        found_count_inc;

    lfu_pkg::unit_ctl_t           ctl;
    lfu_pkg::scan_flags_t         flags;
    logic [ENT_W-1:0]             rd_entry;
    logic [ENT_W-1:0]             wr_entry;
    logic [lfu_pkg::KEY_W-1:0]    ent_key;
    logic [lfu_pkg::DATA_W-1:0]   ent_data;
    logic [COUNT_BITS-1:0]        ent_count;
    logic [IDX_W-1:0]             ent_rank;
    logic [IDX_W-1:0]             found_idx;
    logic [lfu_pkg::DATA_W-1:0]   found_data;
    logic [COUNT_BITS-1:0]        found_count;
    logic [IDX_W-1:0]             found_rank;
    logic [IDX_W-1:0]             victim_idx;
    logic [IDX_W-1:0]             victim_rank;
    logic [IDX_W-1:0]             free_idx;
    logic                         wr_en;
    logic [lfu_pkg::KEY_W-1:0]    wr_key;
    logic [lfu_pkg::DATA_W-1:0]   wr_data;
    logic [COUNT_BITS-1:0]        wr_count;
    logic [IDX_W-1:0]             wr_rank;

    assign busy         = (state_reg != lfu_pkg::ST_IDLE);
    assign accept       = start && !busy;
    assign cfg_ready    = !busy;
    assign result_valid = (state_reg == lfu_pkg::ST_DONE);
    assign hit          = res_hit_reg;
    assign read_value   = res_val_reg;

    assign issue = ((state_reg == lfu_pkg::ST_SCAN) || (state_reg == lfu_pkg::ST_UPDATE)) &&
                   (cnt_reg < CNT_W'(ENTRIES));
    assign raddr = cnt_reg[IDX_W-1:0];
    assign last  = pv_reg && (pidx_reg == IDX_W'(ENTRIES - 1));

    assign cap_wide = CMP_W'(cap_reg);
    assign cap_eff  = (cap_wide > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_wide;
    assign full     = (CMP_W'(occ_reg) >= cap_eff);

    assign found_count_inc = (found_count == '1) ? found_count : found_count + 1'b1;

    assign ctl.clr  = accept;
    assign ctl.scan = (state_reg == lfu_pkg::ST_SCAN) && pv_reg;
    assign ctl.upd  = (state_reg == lfu_pkg::ST_UPDATE) && pv_reg;

    assign {ent_key, ent_data, ent_count, ent_rank} = rd_entry;
    assign wr_entry = {wr_key, wr_data, wr_count, wr_rank};

    lfu_entry_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (ENT_W)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (pidx_reg),
        .wdata (wr_entry),
        .raddr (raddr),
        .rdata (rd_entry)
    );

    lfu_scan_unit #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_unit (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .idx         (pidx_reg),
        .ent_valid   (valid_reg[pidx_reg]),
        .ent_key     (ent_key),
        .ent_data    (ent_data),
        .ent_count   (ent_count),
        .ent_rank    (ent_rank),
        .key         (key_reg),
        .tgt_idx     (tgt_idx_reg),
        .tgt_all     (tgt_all_reg),
        .tgt_rank    (tgt_rank_reg),
        .tgt_data    (tgt_data_reg),
        .tgt_count   (tgt_count_reg),
        .flags       (flags),
        .found_idx   (found_idx),
        .found_data  (found_data),
        .found_count (found_count),
        .found_rank  (found_rank),
        .victim_idx  (victim_idx),
        .victim_rank (victim_rank),
        .free_idx    (free_idx),
        .wr_en       (wr_en),
        .wr_key      (wr_key),
        .wr_data     (wr_data),
        .wr_count    (wr_count),
        .wr_rank     (wr_rank)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pv_next        = issue;
        pidx_next      = issue ? raddr : pidx_reg;
        cap_next       = cap_reg;
        occ_next       = occ_reg;
        valid_next     = valid_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        tgt_idx_next   = tgt_idx_reg;
        tgt_all_next   = tgt_all_reg;
        tgt_rank_next  = tgt_rank_reg;
        tgt_data_next  = tgt_data_reg;
        tgt_count_next = tgt_count_reg;
        res_hit_next   = res_hit_reg;
        res_val_next   = res_val_reg;

        if (cfg_valid && cfg_ready)
        begin
            cap_next = cfg_data;
        end

        if (issue)
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lfu_pkg::ST_SCAN;
                    cnt_next   = '0;
                    cmd_next   = lfu_pkg::cmd_t'(command);
                    key_next   = key;
                    val_next   = data_value;
                end
            end
            lfu_pkg::ST_SCAN:
            begin
                if (last)
                begin
                    state_next = lfu_pkg::ST_DECIDE;
                end
            end
            lfu_pkg::ST_DECIDE:
            begin
                state_next     = lfu_pkg::ST_DONE;
                cnt_next       = '0;
                res_hit_next   = 1'b0;
                res_val_next   = '0;
                tgt_all_next   = 1'b0;
                tgt_count_next = COUNT_BITS'(1);
                tgt_data_next  = val_reg;
                if (cmd_reg == lfu_pkg::CMD_GET)
                begin
                    if (flags.found)
                    begin
                        state_next     = lfu_pkg::ST_UPDATE;
                        res_hit_next   = 1'b1;
                        res_val_next   = found_data;
                        tgt_idx_next   = found_idx;
                        tgt_rank_next  = found_rank;
                        tgt_data_next  = found_data;
                        tgt_count_next = found_count_inc;
                    end
                end
                else if (cap_eff != '0)
                begin
                    if (flags.found)
                    begin
                        state_next     = lfu_pkg::ST_UPDATE;
                        res_hit_next   = 1'b1;
                        tgt_idx_next   = found_idx;
                        tgt_rank_next  = found_rank;
                        tgt_count_next = found_count_inc;
                    end
                    else if (full && flags.victim)
                    begin
                        // eviction and insert into the same slot, occupancy unchanged
                        state_next    = lfu_pkg::ST_UPDATE;
                        tgt_idx_next  = victim_idx;
                        tgt_rank_next = victim_rank;
                    end
                    else if (flags.free)
                    begin
                        state_next             = lfu_pkg::ST_UPDATE;
                        tgt_idx_next           = free_idx;
                        tgt_all_next           = 1'b1;
                        tgt_rank_next          = '0;
                        valid_next[free_idx]   = 1'b1;
                        occ_next               = occ_reg + 1'b1;
                    end
                end
            end
            lfu_pkg::ST_UPDATE:
            begin
                if (last)
                begin
                    state_next = lfu_pkg::ST_DONE;
                end
            end
            lfu_pkg::ST_DONE:
            begin
                state_next = lfu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfu_pkg::ST_IDLE;
            cnt_reg   <= '0;
            pv_reg    <= 1'b0;
            cap_reg   <= lfu_pkg::CAP_RESET;
            occ_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pv_reg    <= pv_next;
            cap_reg   <= cap_next;
            occ_reg   <= occ_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg      <= pidx_next;
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        tgt_idx_reg   <= tgt_idx_next;
        tgt_all_reg   <= tgt_all_next;
        tgt_rank_reg  <= tgt_rank_next;
        tgt_data_reg  <= tgt_data_next;
        tgt_count_reg <= tgt_count_next;
        res_hit_reg   <= res_hit_next;
        res_val_reg   <= res_val_next;
    end

    // occupancy tracks the number of valid entries
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy does not match valid entries");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !result_valid)
        else $error("accepted transaction did not start work");

    a_miss_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !hit) |-> (read_value == '0))
        else $error("miss returned nonzero data");

    a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !busy)
        else $error("block still busy after result");

endmodule
